>>> hdl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PTQ_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the default clk_i / rst_ni pair.
`define PTQ_ASSERT(lbl, prop, msg) \
  `PTQ_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> hdl/ptqrm_pkg.sv
// Package with shared constants, command codes and control/status types.
`timescale 1ns / 1ps

package ptqrm_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned WIN_W   = 20;
  localparam int unsigned VAL_W   = 32;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 20'd60000;

  localparam logic [CMD_W-1:0] CMD_PULSE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RATE  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic push;
    logic pop;
    logic pop_cap;
    logic walk_init;
    logic walk;
    logic mul;
    logic div;
    logic fin_count;
    logic fin_quot;
    logic load_out;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             q_empty;
    logic             walk_done;
    logic             scale;
    logic             div_last;
    logic             out_free;
  } status_t;

endpackage

>>> hdl/pulse_timestamp_queue_rate_meter.sv
// Top level of the pulse timestamp queue with rate meter.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o   in_cmd_i, in_now_ms_i
//   out      output     out_valid_o/out_stall_i out_kind_o, out_ok_o, out_value_o,
//                                               out_total_pulses_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_window_ms_i
//
// One item is processed at a time. A pulse or an empty pop goes from acceptance through
// the execute state to the output register, and a pop with data also passes a capture
// state. A rate query walks the N queued stamps through the single read port of the stamp
// memory and, when scaling applies, runs a bit-serial divider before the output register
// loads. The next item can be taken once the output register has loaded.
// Reset empties the queue, clears the pulse total and loads a 60000 ms window.
// A new item is taken while the previous result waits under out_stall_i.
`timescale 1ns / 1ps

module pulse_timestamp_queue_rate_meter import ptqrm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [WIN_W-1:0] cfg_window_ms_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CMD_W-1:0] in_cmd_i,
  input  logic [VAL_W-1:0] in_now_ms_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CMD_W-1:0] out_kind_o,
  output logic             out_ok_o,
  output logic [VAL_W-1:0] out_value_o,
  output logic [VAL_W-1:0] out_total_pulses_o
);

  ctrl_t   ctrl;
  status_t stat;

  assign cfg_ready_o = 1'b1;

  ptqrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  ptqrm_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_window_ms_i    (cfg_window_ms_i),
    .in_cmd_i           (in_cmd_i),
    .in_now_ms_i        (in_now_ms_i),
    .ctrl_i             (ctrl),
    .stat_o             (stat),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .out_kind_o         (out_kind_o),
    .out_ok_o           (out_ok_o),
    .out_value_o        (out_value_o),
    .out_total_pulses_o (out_total_pulses_o)
  );

endmodule

>>> hdl/ptqrm_datapath.sv
// Datapath: stamp memory, queue pointers, pulse total, walk counter, divider, output register.
`timescale 1ns / 1ps

module ptqrm_datapath import ptqrm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [WIN_W-1:0] cfg_window_ms_i,
  input  logic [CMD_W-1:0] in_cmd_i,
  input  logic [VAL_W-1:0] in_now_ms_i,
  input  ctrl_t            ctrl_i,
  output status_t          stat_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [CMD_W-1:0] out_kind_o,
  output logic             out_ok_o,
  output logic [VAL_W-1:0] out_value_o,
  output logic [VAL_W-1:0] out_total_pulses_o
);

  localparam int unsigned IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned PROD_W = CNT_W + WIN_W;
  localparam int unsigned DCNT_W = $clog2(PROD_W);

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + IDX_W'(1);
    end
    return res;
  endfunction

  logic [VAL_W-1:0] mem [QUEUE_DEPTH];

  logic [WIN_W-1:0]  window_q;
  logic [IDX_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [VAL_W-1:0]  total_q, total_d;
  logic [CMD_W-1:0]  cmd_q;
  logic [VAL_W-1:0]  now_q;
  logic              res_ok_q, res_ok_d;
  logic [VAL_W-1:0]  res_value_q, res_value_d;
  logic [IDX_W-1:0]  walk_idx_q, walk_idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [WIN_W-1:0]  rem_q, rem_d;
  logic [PROD_W-1:0] quo_q, quo_d;
  logic [DCNT_W-1:0] div_cnt_q, div_cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [CMD_W-1:0]  out_kind_q;
  logic              out_ok_q;
  logic [VAL_W-1:0]  out_value_q, out_total_q;

  logic [VAL_W-1:0]  rd_data_q;
  logic              we, re;
  logic [IDX_W-1:0]  raddr;
  logic              full;
  logic [VAL_W-1:0]  age;
  logic              age_ok;
  logic              walk_more;
  logic [PROD_W-1:0] prod;
  logic [WIN_W:0]    trial;
  logic              ge;

  assign full      = (advance(head_q) == tail_q);
  assign walk_more = (walk_idx_q != head_q);
  assign we        = ctrl_i.push && !full;
  assign re        = ctrl_i.pop || (ctrl_i.walk && walk_more);
  assign raddr     = ctrl_i.pop ? tail_q : walk_idx_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[head_q] <= now_q;
    end
    if (re) begin
      rd_data_q <= mem[raddr];
    end
  end

  assign age    = now_q - rd_data_q;
  assign age_ok = (age <= {{(VAL_W - WIN_W){1'b0}}, window_q});

  assign prod  = {{WIN_W{1'b0}}, count_q} * {{CNT_W{1'b0}}, window_q};
  assign trial = {rem_q, quo_q[PROD_W-1]};
  assign ge    = (trial >= {1'b0, now_q[WIN_W-1:0]});

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    total_d     = total_q;
    res_ok_d    = res_ok_q;
    res_value_d = res_value_q;
    walk_idx_d  = walk_idx_q;
    rd_vld_d    = rd_vld_q;
    count_d     = count_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    div_cnt_d   = div_cnt_q;

    if (ctrl_i.accept) begin
      res_ok_d    = 1'b0;
      res_value_d = '0;
    end
    if (ctrl_i.push) begin
      total_d = total_q + VAL_W'(1);
      if (!full) begin
        head_d   = advance(head_q);
        res_ok_d = 1'b1;
      end
    end
    if (ctrl_i.pop) begin
      tail_d   = advance(tail_q);
      res_ok_d = 1'b1;
    end
    if (ctrl_i.pop_cap) begin
      res_value_d = rd_data_q;
    end
    if (ctrl_i.walk_init) begin
      walk_idx_d = tail_q;
      rd_vld_d   = 1'b0;
      count_d    = '0;
    end
    // One read is issued per cycle; its data is checked in the following cycle.
    if (ctrl_i.walk) begin
      if (rd_vld_q && age_ok) begin
        count_d = count_q + CNT_W'(1);
      end
      rd_vld_d = walk_more;
      if (walk_more) begin
        walk_idx_d = advance(walk_idx_q);
      end
    end
    if (ctrl_i.fin_count) begin
      res_value_d = VAL_W'(count_q);
    end
    if (ctrl_i.mul) begin
      quo_d     = prod;
      rem_d     = '0;
      div_cnt_d = '0;
    end
    // Restoring division, one quotient bit per cycle.
    if (ctrl_i.div) begin
      rem_d     = ge ? WIN_W'(trial - {1'b0, now_q[WIN_W-1:0]}) : trial[WIN_W-1:0];
      quo_d     = {quo_q[PROD_W-2:0], ge};
      div_cnt_d = div_cnt_q + DCNT_W'(1);
    end
    if (ctrl_i.fin_quot) begin
      res_value_d = VAL_W'(quo_d);
    end
  end

  assign out_valid_d = ctrl_i.load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= WINDOW_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      total_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        window_q <= cfg_window_ms_i;
      end
      head_q      <= head_d;
      tail_q      <= tail_d;
      total_q     <= total_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q <= in_cmd_i;
      now_q <= in_now_ms_i;
    end
    res_ok_q    <= res_ok_d;
    res_value_q <= res_value_d;
    walk_idx_q  <= walk_idx_d;
    count_q     <= count_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    div_cnt_q   <= div_cnt_d;
    if (ctrl_i.load_out) begin
      out_kind_q  <= cmd_q;
      out_ok_q    <= res_ok_q;
      out_value_q <= res_value_q;
      out_total_q <= total_q;
    end
  end

  assign stat_o.cmd       = cmd_q;
  assign stat_o.q_empty   = (head_q == tail_q);
  assign stat_o.walk_done = !walk_more && !rd_vld_q;
  assign stat_o.scale     = (now_q != '0) && (now_q < {{(VAL_W - WIN_W){1'b0}}, window_q});
  assign stat_o.div_last  = (div_cnt_q == DCNT_W'(PROD_W - 1));
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o        = out_valid_q;
  assign out_kind_o         = out_kind_q;
  assign out_ok_o           = out_ok_q;
  assign out_value_o        = out_value_q;
  assign out_total_pulses_o = out_total_q;

endmodule

>>> hdl/ptqrm_ctrl.sv
// Controller state machine that sequences the datapath for each item.
`timescale 1ns / 1ps

module ptqrm_ctrl import ptqrm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t stat_i,
  output ctrl_t   ctrl_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_POPCAP = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.accept = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (stat_i.cmd == CMD_PULSE) begin
          ctrl_o.push = 1'b1;
          state_d     = S_DONE;
        end else if (stat_i.cmd == CMD_POP) begin
          if (stat_i.q_empty) begin
            state_d = S_DONE;
          end else begin
            ctrl_o.pop = 1'b1;
            state_d    = S_POPCAP;
          end
        end else if (stat_i.cmd == CMD_RATE) begin
          ctrl_o.walk_init = 1'b1;
          state_d          = S_WALK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_POPCAP: begin
        ctrl_o.pop_cap = 1'b1;
        state_d        = S_DONE;
      end
      S_WALK: begin
        ctrl_o.walk = 1'b1;
        if (stat_i.walk_done) begin
          if (stat_i.scale) begin
            state_d = S_MUL;
          end else begin
            ctrl_o.fin_count = 1'b1;
            state_d          = S_DONE;
          end
        end
      end
      S_MUL: begin
        ctrl_o.mul = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        ctrl_o.div = 1'b1;
        if (stat_i.div_last) begin
          ctrl_o.fin_quot = 1'b1;
          state_d         = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          ctrl_o.load_out = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

>>> hdl/ptqrm_checker.sv
// Port-level checker for the rate meter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptqrm_checker import ptqrm_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [CMD_W-1:0] out_kind_o,
  input logic             out_ok_o,
  input logic [VAL_W-1:0] out_value_o
);

  // A stalled result stays on the port.
  `PTQ_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "stalled result dropped")

  // The block is busy in the cycle after it takes an item.
  `PTQ_ASSERT_CLK(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o, "accepted twice in a row")

  // A rate result never reports ok.
  `PTQ_ASSERT(a_rate_ok_low, out_valid_o && out_kind_o == CMD_RATE |-> !out_ok_o, "rate result with ok set")

  // An empty pop returns zero.
  `PTQ_ASSERT(a_empty_pop_zero, out_valid_o && out_kind_o == CMD_POP && !out_ok_o |-> out_value_o == '0, "empty pop with nonzero value")

endmodule

bind pulse_timestamp_queue_rate_meter ptqrm_checker u_ptqrm_checker (.*);

>>> tb/sv/testbench.sv
// Self-checking testbench for the pulse timestamp queue with rate meter.
`timescale 1ns / 1ps

import ptqrm_pkg::*;

typedef struct packed {
  logic [CMD_W-1:0] kind;
  logic             ok;
  logic [VAL_W-1:0] value;
  logic [VAL_W-1:0] total;
} meter_result_t;

class rate_meter_scoreboard;
  logic [VAL_W-1:0] stamps [QUEUE_DEPTH_DEF];
  int unsigned      head_slot;
  int unsigned      tail_slot;
  logic [VAL_W-1:0] pulse_count;
  logic [WIN_W-1:0] window;
  meter_result_t    results_due [$];
  int unsigned      mismatches;

  function new();
    head_slot   = 0;
    tail_slot   = 0;
    pulse_count = '0;
    window      = WINDOW_RESET;
    mismatches  = 0;
  endfunction

  function int unsigned next_slot(int unsigned slot);
    return (slot + 1 >= QUEUE_DEPTH_DEF) ? 0 : slot + 1;
  endfunction

  function void set_window(logic [WIN_W-1:0] w);
    window = w;
  endfunction

  function int unsigned pending();
    return results_due.size();
  endfunction

  // Counts stamps whose wrapping age fits the window, scaled up early in the window.
  function logic [VAL_W-1:0] windowed_count(logic [VAL_W-1:0] now);
    longint unsigned  cnt;
    int unsigned      slot;
    logic [VAL_W-1:0] age;
    cnt  = 0;
    slot = tail_slot;
    while (slot != head_slot) begin
      age = now - stamps[slot];
      if (age <= VAL_W'(window)) cnt++;
      slot = next_slot(slot);
    end
    if (now != 0 && now < VAL_W'(window)) cnt = (cnt * window) / now;
    return VAL_W'(cnt);
  endfunction

  function void note_item(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] now);
    meter_result_t r;
    r.kind  = cmd;
    r.ok    = 1'b0;
    r.value = '0;
    case (cmd)
      CMD_PULSE: begin
        if (next_slot(head_slot) != tail_slot) begin
          stamps[head_slot] = now;
          head_slot = next_slot(head_slot);
          r.ok = 1'b1;
        end
        pulse_count = pulse_count + 1;
      end
      CMD_POP: begin
        if (head_slot != tail_slot) begin
          r.value   = stamps[tail_slot];
          tail_slot = next_slot(tail_slot);
          r.ok      = 1'b1;
        end
      end
      CMD_RATE: begin
        r.value = windowed_count(now);
      end
      default: begin
      end
    endcase
    r.total = pulse_count;
    results_due.push_back(r);
  endfunction

  function void report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    $display("MISMATCH %s: got 0x%08h, expected 0x%08h", what, got, want);
    mismatches++;
  endfunction

  function void check_result(meter_result_t got);
    meter_result_t want;
    if (results_due.size() == 0) begin
      report_mismatch("result with no item waiting", got.value, '0);
      return;
    end
    want = results_due.pop_front();
    if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
    if (got.ok != want.ok) report_mismatch("ok", got.ok, want.ok);
    if (got.value != want.value) report_mismatch("value", got.value, want.value);
    if (got.total != want.total) report_mismatch("total_pulses", got.total, want.total);
  endfunction
endclass

module testbench;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned PHASE_ITEMS   = 305;
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef enum {IDLE_SENDER_LIGHT, IDLE_SENDER_HEAVY, IDLE_NONE} idle_mode_t;
  typedef enum {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [WIN_W-1:0] cfg_window_ms_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [CMD_W-1:0] in_cmd_i;
  logic [VAL_W-1:0] in_now_ms_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [CMD_W-1:0] out_kind_o;
  logic             out_ok_o;
  logic [VAL_W-1:0] out_value_o;
  logic [VAL_W-1:0] out_total_pulses_o;

  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  int unsigned      hold_left;
  logic [VAL_W-1:0] tick;
  rate_meter_scoreboard sb;

  pulse_timestamp_queue_rate_meter uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_window_ms_i    (cfg_window_ms_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_cmd_i           (in_cmd_i),
    .in_now_ms_i        (in_now_ms_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_kind_o         (out_kind_o),
    .out_ok_o           (out_ok_o),
    .out_value_o        (out_value_o),
    .out_total_pulses_o (out_total_pulses_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // A long hold-off, once requested, overrides the random receiver stalls.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left   = hold_left - 1;
    end else begin
      out_stall_i = ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_item(in_cmd_i, in_now_ms_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(meter_result_t'{out_kind_o, out_ok_o, out_value_o,
                                        out_total_pulses_o});
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER_LIGHT: begin
        send_idle_pct = 24;
        recv_idle_pct = 76;
      end
      IDLE_SENDER_HEAVY: begin
        send_idle_pct = 76;
        recv_idle_pct = 24;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_cmd_i    = cmd;
    in_now_ms_i = now;
    in_valid_i  = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] w);
    cfg_window_ms_i = w;
    cfg_valid_i     = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_window(w);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Stamps follow a slowly advancing tick so that ages straddle the window edge.
  task automatic random_item(input burst_t burst, input int unsigned step_max,
                             input int unsigned w);
    int unsigned      roll;
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] now;
    roll = $urandom_range(99);
    case (burst)
      BURST_FILL:  cmd = (roll < 80) ? CMD_PULSE : (roll < 95) ? CMD_RATE : CMD_POP;
      BURST_DRAIN: cmd = (roll < 70) ? CMD_POP : (roll < 90) ? CMD_RATE : CMD_PULSE;
      default:     cmd = (roll < 40) ? CMD_PULSE : (roll < 70) ? CMD_POP :
                         (roll < 95) ? CMD_RATE : CMD_SPARE;
    endcase
    if ($urandom_range(39) == 0) begin
      case ($urandom_range(2))
        0:       tick = $urandom_range(w);
        1:       tick = '1 - $urandom_range(w);
        default: tick = $urandom;
      endcase
    end
    roll = $urandom_range(99);
    case (cmd)
      CMD_PULSE: begin
        tick = tick + $urandom_range(step_max);
        now  = tick;
      end
      CMD_RATE: begin
        if (roll < 70) now = tick;
        else if (roll < 90) now = tick + $urandom_range(4 * step_max);
        else now = $urandom;
      end
      default: now = $urandom;
    endcase
    send_item(cmd, now);
  endtask

  task automatic run_phase(input idle_mode_t mode, input logic [WIN_W-1:0] w,
                           input bit hold);
    int unsigned step_max;
    int unsigned burst_len;
    int unsigned done;
    burst_t      burst;
    wait_drain();
    write_window(w);
    set_idle(mode);
    step_max  = w / 16 + 1;
    burst_len = 0;
    burst     = BURST_MIXED;
    case ($urandom_range(2))
      0:       tick = '0;
      1:       tick = '1 - $urandom_range(4 * w);
      default: tick = $urandom;
    endcase
    if (hold) hold_left = HOLD_CYCLES;
    for (done = 0; done < PHASE_ITEMS; done++) begin
      if (burst_len == 0) begin
        burst     = burst_t'($urandom_range(2));
        burst_len = $urandom_range(20, 80);
      end
      random_item(burst, step_max, w);
      burst_len--;
      if (done == PHASE_ITEMS / 2) wait_drain();
    end
  endtask

  initial begin
    sb              = new();
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_window_ms_i = '0;
    in_valid_i      = 1'b0;
    in_cmd_i        = CMD_PULSE;
    in_now_ms_i     = '0;
    out_stall_i     = 1'b0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    hold_left       = 0;
    tick            = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items on the reset window: empty queue, tick zero, window edges, wrap.
    set_idle(IDLE_SENDER_LIGHT);
    send_item(CMD_RATE, '0);
    send_item(CMD_POP, '1);
    send_item(CMD_PULSE, '0);
    send_item(CMD_PULSE, '1);
    send_item(CMD_PULSE, VAL_W'(WINDOW_RESET) - 1);
    send_item(CMD_RATE, '0);
    send_item(CMD_RATE, 32'd1);
    send_item(CMD_RATE, VAL_W'(WINDOW_RESET) - 1);
    send_item(CMD_RATE, VAL_W'(WINDOW_RESET));
    send_item(CMD_RATE, '1);
    send_item(CMD_SPARE, '1);
    send_item(CMD_POP, '0);
    send_item(CMD_POP, '0);
    send_item(CMD_RATE, VAL_W'(WINDOW_RESET) - 1);
    send_item(CMD_POP, '1);
    send_item(CMD_POP, '0);
    send_item(CMD_SPARE, '0);

    // A zero window only counts stamps of age zero and never scales.
    wait_drain();
    write_window('0);
    send_item(CMD_PULSE, 32'd1234);
    send_item(CMD_RATE, 32'd1234);
    send_item(CMD_RATE, 32'd1235);
    send_item(CMD_POP, '0);

    wait_drain();
    write_window('1);
    send_item(CMD_PULSE, 32'd5);
    send_item(CMD_RATE, 32'h000F_FFFE);
    send_item(CMD_RATE, 32'd1);

    run_phase(IDLE_SENDER_LIGHT, 20'd1, 1'b0);
    run_phase(IDLE_SENDER_LIGHT, WINDOW_RESET, 1'b0);
    run_phase(IDLE_SENDER_HEAVY, WIN_W'($urandom_range(1, 20'hFFFFF)), 1'b0);
    run_phase(IDLE_SENDER_HEAVY, 20'hFFFFF, 1'b0);
    run_phase(IDLE_NONE, WIN_W'($urandom_range(2, 500)), 1'b1);
    run_phase(IDLE_NONE, WINDOW_RESET, 1'b0);

    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+hdl
hdl/ptqrm_pkg.sv
hdl/ptqrm_datapath.sv
hdl/ptqrm_ctrl.sv
hdl/pulse_timestamp_queue_rate_meter.sv
hdl/ptqrm_checker.sv
tb/sv/testbench.sv
